@@ rtl/edfs_pkg.sv @@
package edfs_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned WORK_W = 16;
	localparam int unsigned CFGF_W = 16;
	localparam int unsigned NUM_W  = 5;
	localparam int unsigned MASK_W = 16;
	localparam int unsigned TID_W  = 4;

	// input action codes
	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// per-task run-time state
	typedef struct packed {
		logic [TIME_W-1:0] next_rel;
		logic [WORK_W-1:0] rem_work;
		logic [TIME_W-1:0] abs_dl;
	} dyn_t;

	// per-task static parameters
	typedef struct packed {
		logic [CFGF_W-1:0] exec_time;
		logic [CFGF_W-1:0] period;
		logic [CFGF_W-1:0] rel_dl;
	} tcfg_t;

	// table write strobes
	typedef struct packed {
		logic cfg_we;
		logic dyn_we;
		logic rw_we;
	} tbl_ctl_t;

	// saturating time add
	function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
		input logic [CFGF_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {{(TIME_W+1-CFGF_W){1'b0}}, b};
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

@@ rtl/edfs_table.sv @@
// Task table: static parameters and run-time state, one write and one
// registered read per cycle.
module edfs_table #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic               clk,
	input  edfs_pkg::tbl_ctl_t ctl,
	input  logic [AW-1:0]      waddr,
	input  edfs_pkg::dyn_t     wdyn,
	input  edfs_pkg::tcfg_t    wcfg,
	input  logic [AW-1:0]      raddr,
	output edfs_pkg::dyn_t     rdyn,
	output edfs_pkg::tcfg_t    rcfg
);

	logic [edfs_pkg::TIME_W-1:0] nr_mem [DEPTH];
	logic [edfs_pkg::WORK_W-1:0] rw_mem [DEPTH];
	logic [edfs_pkg::TIME_W-1:0] ad_mem [DEPTH];
	edfs_pkg::tcfg_t             cf_mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (ctl.cfg_we) begin
			cf_mem[waddr] <= wcfg;
		end
		if (ctl.dyn_we) begin
			nr_mem[waddr] <= wdyn.next_rel;
			ad_mem[waddr] <= wdyn.abs_dl;
		end
		if (ctl.dyn_we || ctl.rw_we) begin
			rw_mem[waddr] <= wdyn.rem_work;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdyn.next_rel <= nr_mem[raddr];
		rdyn.rem_work <= rw_mem[raddr];
		rdyn.abs_dl   <= ad_mem[raddr];
		rcfg          <= cf_mem[raddr];
	end

endmodule

@@ rtl/edfs_eval.sv @@
// Per-entry evaluation unit, shared by every entry of the scan: release
// check and refill, then earliest-deadline compare against the best so far.
module edfs_eval (
	input  logic [edfs_pkg::TIME_W-1:0] now,
	input  edfs_pkg::dyn_t              cur,
	input  edfs_pkg::tcfg_t             cfg,
	input  logic                        found,
	input  logic [edfs_pkg::TIME_W-1:0] best_dl,
	output logic                        released,
	output edfs_pkg::dyn_t              upd,
	output logic                        better
);

	logic cand;

	// release: refill work, set deadline, advance next release
	always_comb begin
		released = (cur.next_rel == now);
		if (released) begin
			upd.next_rel = edfs_pkg::sat_add(cur.next_rel, cfg.period);
			upd.rem_work = cfg.exec_time;
			upd.abs_dl   = edfs_pkg::sat_add(now, cfg.rel_dl);
		end else begin
			upd = cur;
		end
	end

	// strict compare keeps the lowest index on ties
	assign cand   = (upd.rem_work != '0) && (upd.abs_dl > now);
	assign better = cand && (!found || (upd.abs_dl < best_dl));

endmodule

@@ rtl/edf_task_scheduler.sv @@
// Earliest-deadline-first scheduler for periodic tasks. A load item writes one
// task entry, zeroes its run-time state and resets time to 0. A tick item walks
// entries 0..n-1 (n = min(num_tasks, MAX_TASKS)) through one shared evaluation
// unit, one entry per cycle off the table's registered read port, then charges
// one work unit to the winner. The result sits in an output register, so the
// scan of the next item can start while it waits. num_tasks is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, as the
// block itself does not enforce this.
module edf_task_scheduler #(
	parameter int unsigned MAX_TASKS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [edfs_pkg::NUM_W-1:0]  cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        action,
	input  logic [3:0]                  task_index,
	input  logic [15:0]                 exec_time,
	input  logic [15:0]                 period,
	input  logic [15:0]                 rel_deadline,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [edfs_pkg::MASK_W-1:0] released_mask,
	output logic                        ran,
	output logic [edfs_pkg::TID_W-1:0]  running_task,
	output logic                        completed,
	output logic [edfs_pkg::TIME_W-1:0] current_time
);

	localparam int unsigned IDXW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned NW   = $clog2(MAX_TASKS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_POST = 4'b1000
	} state_t;

	state_t                        state_q;
	logic [edfs_pkg::NUM_W-1:0]    num_tasks_q;
	logic [edfs_pkg::TIME_W-1:0]   tick_q;
	logic [edfs_pkg::TIME_W-1:0]   now_q;
	logic [NW-1:0]                 n_cnt;
	logic [NW-1:0]                 rd_ptr_q;
	logic                          vld_s1;
	logic [IDXW-1:0]               idx_s1;
	logic                          found_q;
	logic [IDXW-1:0]               best_q;
	logic [edfs_pkg::TIME_W-1:0]   best_dl_q;
	logic [edfs_pkg::WORK_W-1:0]   best_rw_q;
	logic                          done_q;
	logic [edfs_pkg::MASK_W-1:0]   mask_q;
	logic                          out_valid_q;

	logic                          in_xfer;
	logic                          ld_hit;
	edfs_pkg::tbl_ctl_t            tctl;
	logic [IDXW-1:0]               waddr;
	edfs_pkg::dyn_t                wdyn;
	edfs_pkg::tcfg_t               wcfg;
	edfs_pkg::dyn_t                rdyn;
	edfs_pkg::tcfg_t               rcfg;
	logic                          ev_rel;
	edfs_pkg::dyn_t                ev_upd;
	logic                          ev_better;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign ld_hit    = (32'(task_index) < 32'(MAX_TASKS));

	// entries in use, clamped to the table size
	assign n_cnt = (32'(num_tasks_q) > 32'(MAX_TASKS)) ? NW'(MAX_TASKS) : NW'(num_tasks_q);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_tasks_q <= edfs_pkg::NUM_W'(1);
		end else if (cfg_we) begin
			num_tasks_q <= cfg_wdata;
		end
	end

	// table write port select: load, scan write-back, final charge
	always_comb begin
		tctl           = '0;
		waddr          = idx_s1;
		wdyn           = ev_upd;
		wcfg.exec_time = exec_time;
		wcfg.period    = period;
		wcfg.rel_dl    = rel_deadline;
		if (in_xfer && (action == edfs_pkg::ACT_LOAD)) begin
			tctl.cfg_we = ld_hit;
			tctl.dyn_we = ld_hit;
			waddr       = IDXW'(task_index);
			wdyn        = '0;
		end else if ((state_q == ST_SCAN) && vld_s1) begin
			tctl.dyn_we = ev_rel;
		end else if ((state_q == ST_FIN) && found_q) begin
			tctl.rw_we    = 1'b1;
			waddr         = best_q;
			wdyn.rem_work = best_rw_q - 1'b1;
		end
	end

	edfs_table #(
		.DEPTH(MAX_TASKS),
		.AW   (IDXW)
	) u_table (
		.clk  (clk),
		.ctl  (tctl),
		.waddr(waddr),
		.wdyn (wdyn),
		.wcfg (wcfg),
		.raddr(rd_ptr_q[IDXW-1:0]),
		.rdyn (rdyn),
		.rcfg (rcfg)
	);

	edfs_eval u_eval (
		.now     (now_q),
		.cur     (rdyn),
		.cfg     (rcfg),
		.found   (found_q),
		.best_dl (best_dl_q),
		.released(ev_rel),
		.upd     (ev_upd),
		.better  (ev_better)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tick_q   <= '0;
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						found_q  <= 1'b0;
						rd_ptr_q <= '0;
						vld_s1   <= 1'b0;
						if (action == edfs_pkg::ACT_LOAD) begin
							tick_q  <= '0;
							state_q <= ST_POST;
						end else begin
							state_q <= (n_cnt == '0) ? ST_FIN : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// issue one read per cycle, evaluate the one issued last cycle
					if (rd_ptr_q < n_cnt) begin
						rd_ptr_q <= NW'(rd_ptr_q + 1'b1);
						vld_s1   <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (vld_s1 && ev_better) begin
						found_q <= 1'b1;
					end
					if (!vld_s1 && (rd_ptr_q == n_cnt)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					tick_q  <= (tick_q == '1) ? tick_q : tick_q + 1'b1;
					state_q <= ST_POST;
				end
				ST_POST: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan datapath and result staging
	always_ff @(posedge clk) begin
		idx_s1 <= rd_ptr_q[IDXW-1:0];
		if (in_xfer) begin
			now_q  <= (action == edfs_pkg::ACT_LOAD) ? '0 : tick_q;
			mask_q <= '0;
			best_q <= '0;
			done_q <= 1'b0;
		end
		if ((state_q == ST_SCAN) && vld_s1) begin
			if (ev_rel && (32'(idx_s1) < 32'(edfs_pkg::MASK_W))) begin
				mask_q[edfs_pkg::TID_W'(idx_s1)] <= 1'b1;
			end
			if (ev_better) begin
				best_q    <= idx_s1;
				best_dl_q <= ev_upd.abs_dl;
				best_rw_q <= ev_upd.rem_work;
			end
		end
		if ((state_q == ST_FIN) && found_q) begin
			done_q <= (best_rw_q == edfs_pkg::WORK_W'(1));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_POST) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_POST) && (!out_valid_q || out_ready)) begin
			released_mask <= mask_q;
			ran           <= found_q;
			running_task  <= edfs_pkg::TID_W'(best_q);
			completed     <= found_q && done_q;
			current_time  <= now_q;
		end
	end

	// checks
	a_load_clears_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (action == edfs_pkg::ACT_LOAD)) |=> (tick_q == '0) && (state_q == ST_POST))
		else $error("load did not clear time");

	a_s1_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && (state_q != ST_IDLE)) |-> (state_q == ST_SCAN))
		else $error("evaluation stage active outside the scan");

	a_best_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && found_q) |-> (32'(best_q) < 32'(n_cnt)))
		else $error("selected task outside the entries in use");

	a_fin_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> (!vld_s1 && (rd_ptr_q == n_cnt)))
		else $error("scan finished before all entries were evaluated");

endmodule

@@ verif/edf_task_scheduler_chk.sv @@
module edf_task_scheduler_chk (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        action,
	input  logic [3:0]  task_index,
	input  logic [15:0] exec_time,
	input  logic [15:0] period,
	input  logic [15:0] rel_deadline,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] released_mask,
	input  logic        ran,
	input  logic [3:0]  running_task,
	input  logic        completed,
	input  logic [31:0] current_time,
	output int          err_count,
	output int          exp_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SIZE = 16;

	typedef struct packed {
		logic [15:0] mask;
		logic        ran;
		logic [3:0]  who;
		logic        done;
		logic [31:0] now;
	} sched_res_t;

	// shadow copy of the scheduler state
	logic [4:0]  num_sel;
	logic [31:0] tick_now;
	logic [31:0] nxt_rel   [TABLE_SIZE];
	logic [15:0] work_left [TABLE_SIZE];
	logic [31:0] due       [TABLE_SIZE];
	logic [15:0] t_exec    [TABLE_SIZE];
	logic [15:0] t_per     [TABLE_SIZE];
	logic [15:0] t_dl      [TABLE_SIZE];

	sched_res_t sched_q [$];
	sched_res_t predicted, oldest, got;
	int         n_results;

	// saturating 32-bit time add
	function automatic logic [31:0] time_add(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] s;
		s = a + b;
		return (s < a) ? 32'hFFFF_FFFF : s;
	endfunction

	// one load or one tick of the EDF scheduler
	task automatic schedule_step(input logic act, input logic [3:0] idx,
		input logic [15:0] e, input logic [15:0] p, input logic [15:0] d,
		output sched_res_t r);
		int         n;
		int         best;
		bit         found;
		logic [31:0] now;
		r = '0;
		if (act == edfs_pkg::ACT_LOAD) begin
			t_exec[idx]    = e;
			t_per[idx]     = p;
			t_dl[idx]      = d;
			nxt_rel[idx]   = '0;
			work_left[idx] = '0;
			due[idx]       = '0;
			tick_now       = '0;
		end else begin
			n     = (num_sel > TABLE_SIZE) ? TABLE_SIZE : int'(num_sel);
			now   = tick_now;
			found = 1'b0;
			best  = 0;
			// releases due now
			for (int i = 0; i < n; i++) begin
				if (nxt_rel[i] == now) begin
					nxt_rel[i]   = time_add(nxt_rel[i], {16'd0, t_per[i]});
					work_left[i] = t_exec[i];
					due[i]       = time_add(now, {16'd0, t_dl[i]});
					r.mask[i]    = 1'b1;
				end
			end
			// earliest live deadline, lowest index on a tie
			for (int i = 0; i < n; i++) begin
				if (work_left[i] != 0 && due[i] > now) begin
					if (!found || due[i] < due[best]) begin
						best  = i;
						found = 1'b1;
					end
				end
			end
			if (found) begin
				work_left[best] = work_left[best] - 16'd1;
				r.ran  = 1'b1;
				r.who  = 4'(best);
				r.done = (work_left[best] == 0);
			end
			r.now    = now;
			tick_now = time_add(tick_now, 32'd1);
		end
	endtask

	// track transfers, predict and compare in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_sel   = 5'd1;
			tick_now  = '0;
			for (int i = 0; i < TABLE_SIZE; i++) begin
				nxt_rel[i]   = '0;
				work_left[i] = '0;
				due[i]       = '0;
				t_exec[i]    = '0;
				t_per[i]     = '0;
				t_dl[i]      = '0;
			end
			sched_q.delete();
			n_results = 0;
			err_count = 0;
			exp_count = 0;
		end else begin
			if (cfg_we)
				num_sel = cfg_wdata;
			if (in_valid && in_ready) begin
				schedule_step(action, task_index, exec_time, period, rel_deadline, predicted);
				sched_q.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				got = '{released_mask, ran, running_task, completed, current_time};
				if (sched_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("result %0d: unexpected, got mask %h ran %0d task %0d done %0d time %0d",
							n_results, got.mask, got.ran, got.who, got.done, got.now);
				end else begin
					oldest = sched_q.pop_front();
					if (got.mask !== oldest.mask || got.ran !== oldest.ran ||
						got.who !== oldest.who || got.done !== oldest.done ||
						got.now !== oldest.now) begin
						err_count++;
						if (err_count <= 10)
							$display("result %0d: expected mask %h ran %0d task %0d done %0d time %0d, got mask %h ran %0d task %0d done %0d time %0d",
								n_results, oldest.mask, oldest.ran, oldest.who, oldest.done,
								oldest.now, got.mask, got.ran, got.who, got.done, got.now);
					end
				end
				n_results++;
			end
			exp_count = sched_q.size();
		end
	end

endmodule

@@ verif/edf_task_scheduler_tb.sv @@
module edf_task_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WD_LIMIT    = 3000;
	localparam int PHASE_ITEMS = 85;
	localparam int NUM_PHASES  = 10;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic [3:0]  task_index;
	logic [15:0] exec_time;
	logic [15:0] period;
	logic [15:0] rel_deadline;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] released_mask;
	logic        ran;
	logic [3:0]  running_task;
	logic        completed;
	logic [31:0] current_time;

	int          chk_errors;
	int          chk_pending;
	int          idle_cyc;
	bit          quiet;
	bit          send_gaps;
	bit          press_req;
	logic [4:0]  phase_cfg [NUM_PHASES];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	edf_task_scheduler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.task_index    (task_index),
		.exec_time     (exec_time),
		.period        (period),
		.rel_deadline  (rel_deadline),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.released_mask (released_mask),
		.ran           (ran),
		.running_task  (running_task),
		.completed     (completed),
		.current_time  (current_time)
	);

	edf_task_scheduler_chk u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.task_index    (task_index),
		.exec_time     (exec_time),
		.period        (period),
		.rel_deadline  (rel_deadline),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.released_mask (released_mask),
		.ran           (ran),
		.running_task  (running_task),
		.completed     (completed),
		.current_time  (current_time),
		.err_count     (chk_errors),
		.exp_count     (chk_pending)
	);

	// offer one item, with an optional gap first, and wait for its transfer
	task automatic put_item(input logic act, input logic [3:0] idx,
		input logic [15:0] e, input logic [15:0] p, input logic [15:0] d);
		int k;
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			k = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (k) @(posedge clk);
		end
		in_valid     <= 1'b1;
		action       <= act;
		task_index   <= idx;
		exec_time    <= e;
		period       <= p;
		rel_deadline <= d;
		do @(posedge clk); while (!in_ready);
	endtask

	// drain: no more results owed, then let the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_num(input logic [4:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cyc <= 0;
		else
			idle_cyc <= idle_cyc + 1;
		if (idle_cyc >= WD_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side: random stalls, calm stretches, one long hold-off
	initial begin : rx_side
		int  calm;
		bit  press_done;
		calm       = 0;
		press_done = 1'b0;
		out_ready  = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (press_req && !press_done) begin
				press_done = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else if (!quiet && calm == 0 && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				if (calm > 0)
					calm--;
				else if ($urandom_range(0, 30) == 0)
					calm = $urandom_range(20, 120);
				@(posedge clk);
			end
		end
	end

	// stimulus
	initial begin : tx_side
		int          sent;
		int          cnt;
		int          cur_n;
		logic [15:0] e;
		logic [15:0] p;
		logic [15:0] d;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		in_valid     = 1'b0;
		action       = edfs_pkg::ACT_LOAD;
		task_index   = '0;
		exec_time    = '0;
		period       = '0;
		rel_deadline = '0;
		quiet        = 1'b0;
		press_req    = 1'b0;
		send_gaps    = 1'b1;
		phase_cfg    = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd8, 5'd17, 5'd0, 5'd0, 5'd16};
		phase_cfg[7] = 5'($urandom_range(0, 31));
		phase_cfg[8] = 5'($urandom_range(0, 31));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: fill the whole table, ties on the first two entries
		put_item(edfs_pkg::ACT_LOAD, 4'd0, 16'd2, 16'd4, 16'd3);
		put_item(edfs_pkg::ACT_LOAD, 4'd1, 16'd1, 16'd3, 16'd3);
		put_item(edfs_pkg::ACT_LOAD, 4'd2, 16'd3, 16'd8, 16'd8);
		put_item(edfs_pkg::ACT_LOAD, 4'd3, 16'd1, 16'd1, 16'd1);
		for (int i = 4; i < 12; i++)
			put_item(edfs_pkg::ACT_LOAD, 4'(i), 16'($urandom_range(1, 5)),
				16'($urandom_range(2, 20)), 16'($urandom_range(1, 20)));
		// zero deadline, zero period, zero work, all-ones entry
		put_item(edfs_pkg::ACT_LOAD, 4'd12, 16'd2, 16'd5, 16'd0);
		put_item(edfs_pkg::ACT_LOAD, 4'd13, 16'd1, 16'd0, 16'd4);
		put_item(edfs_pkg::ACT_LOAD, 4'd14, 16'd0, 16'd6, 16'd6);
		put_item(edfs_pkg::ACT_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		wait_idle();
		write_num(5'd16);
		for (int i = 0; i < 8; i++)
			put_item(edfs_pkg::ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom));
		wait_idle();

		// random phases, one table size each
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph == NUM_PHASES - 1)
				quiet = 1'b1;
			write_num(phase_cfg[ph]);
			if (ph == 1)
				press_req = 1'b1;
			cur_n = (phase_cfg[ph] > 16) ? 16 : int'(phase_cfg[ph]);
			sent  = 0;
			while (sent < PHASE_ITEMS) begin
				send_gaps = !quiet && ($urandom_range(0, 2) != 0);
				if ($urandom_range(0, 9) == 0) begin
					// noise: wide-valued load anywhere, or a stray tick
					put_item($urandom_range(0, 1) ? edfs_pkg::ACT_TICK : edfs_pkg::ACT_LOAD,
						4'($urandom),
						16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
						16'($urandom_range(1, 65535)));
					sent++;
				end else begin
					// reload a few entries, then run the schedule for a while
					cnt = $urandom_range(1, 3);
					for (int j = 0; j < cnt && sent < PHASE_ITEMS; j++) begin
						e = 16'($urandom_range(1, 6));
						p = 16'($urandom_range(2, 24));
						d = 16'($urandom_range(1, int'(p) + 6));
						if (cur_n > 0 && $urandom_range(0, 3) != 0)
							put_item(edfs_pkg::ACT_LOAD, 4'($urandom_range(0, cur_n - 1)),
								e, p, d);
						else
							put_item(edfs_pkg::ACT_LOAD, 4'($urandom), e, p, d);
						sent++;
					end
					cnt = $urandom_range(8, 50);
					for (int j = 0; j < cnt && sent < PHASE_ITEMS; j++) begin
						put_item(edfs_pkg::ACT_TICK, 4'($urandom), 16'($urandom),
							16'($urandom), 16'($urandom));
						sent++;
					end
				end
			end
			wait_idle();
		end

		if (chk_errors == 0 && chk_pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
